// File: src/printer_link_packet_receiver_assert.svh
// assertion macros for the printer link packet receiver
`ifndef PRINTER_LINK_PACKET_RECEIVER_ASSERT_SVH
`define PRINTER_LINK_PACKET_RECEIVER_ASSERT_SVH

// property that holds on every clock edge outside reset
`define PLPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the following cycle
`define PLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/plpr_pkg.sv
// ----------------------------------------------------------------------------
// plpr_pkg
// types and constants shared by the printer link packet receiver
// ----------------------------------------------------------------------------
package plpr_pkg;

  localparam int unsigned ImageBytes = 5760;
  localparam int unsigned AddrW = 13;
  localparam int unsigned GapW = 20;
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] CmdInit     = 8'h01;
  localparam logic [7:0] CmdPrint    = 8'h02;
  localparam logic [7:0] CmdData     = 8'h04;
  localparam logic [7:0] CmdStatus   = 8'h0F;
  localparam logic [7:0] CmdTransfer = 8'h10;

  localparam logic [7:0] Sync1Byte = 8'h88;
  localparam logic [7:0] Sync2Byte = 8'h33;
  localparam logic [7:0] DeviceId  = 8'h81;

  localparam int unsigned StCksum    = 0;
  localparam int unsigned StPrinting = 1;
  localparam int unsigned StFull     = 2;
  localparam int unsigned StReady    = 3;
  localparam int unsigned StPktErr   = 4;

  localparam logic [1:0] RegHard     = 2'd0;
  localparam logic [1:0] RegSoft     = 2'd1;
  localparam logic [1:0] RegTransfer = 2'd2;

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CMD, PH_COMP, PH_LENL, PH_LENH,
    PH_DATA, PH_SUML, PH_SUMH, PH_ALIVE, PH_STATUS
  } phase_e;

  // classified transaction handed from front to back
  typedef struct packed {
    logic       finished;
    logic       hard_to;
    logic       soft_to;
    logic       is_zero;
    logic       is_sync1;
    logic       is_sync2;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       reply_byte;
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [7:0]       write_data;
    logic             data_event;
    logic             print_event;
    logic             complete_event;
    logic [7:0]       sheets;
    logic [7:0]       margins;
    logic [7:0]       palette;
    logic [7:0]       exposure;
    logic [AddrW-1:0] image_bytes;
  } result_t;

endpackage

// File: src/plpr_front.sv
// ----------------------------------------------------------------------------
// plpr_front
// accepts transactions, compares the gap with the timeouts, feeds the queue
// ----------------------------------------------------------------------------
module plpr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [19:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [plpr_pkg::GapW-1:0]  gap_us_i,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output plpr_pkg::item_t            q_item_o
);

  logic [19:0] hard_q, soft_q;
  plpr_pkg::item_t mem_q [plpr_pkg::QDepth];
  logic wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  plpr_pkg::item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_q <= 20'd125000;
      soft_q <= 20'd20000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == plpr_pkg::RegHard) hard_q <= cfg_data_i;
      if (cfg_index_i == plpr_pkg::RegSoft) soft_q <= cfg_data_i;
    end
  end

  always_comb begin
    item.finished = operation_i;
    item.hard_to  = gap_us_i > hard_q;
    item.soft_to  = gap_us_i > soft_q;
    item.is_zero  = rx_byte_i == 8'h00;
    item.is_sync1 = rx_byte_i == plpr_pkg::Sync1Byte;
    item.is_sync2 = rx_byte_i == plpr_pkg::Sync2Byte;
    item.rx_byte  = rx_byte_i;
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/plpr_back.sv
// ----------------------------------------------------------------------------
// plpr_back
// packet state machine and registered result stage
// ----------------------------------------------------------------------------
module plpr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  plpr_pkg::item_t       q_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plpr_pkg::result_t     res_o
);

  localparam int unsigned AW = plpr_pkg::AddrW;

  logic [15:0] xfer_len_q;
  plpr_pkg::phase_e phase_q, phase_d;
  logic [4:0]  zrun_q, zrun_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d, idx_q, idx_d, sum_q, sum_d, rsum_q, rsum_d;
  logic [4:0]  st_q, st_d;
  logic        pf_q, pf_d;
  logic [AW-1:0] img_q, img_d;
  logic [7:0]  set_q [4];
  logic [7:0]  set_d [4];
  logic        ovalid_q;
  plpr_pkg::result_t res_q, res_d;
  logic        step;

  assign q_ready_o = !ovalid_q || out_ready_i;
  assign step = q_valid_i && q_ready_o;
  assign out_valid_o = ovalid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) xfer_len_q <= 16'd4;
    else if (cfg_we_i && cfg_index_i == plpr_pkg::RegTransfer) xfer_len_q <= cfg_data_i;
  end

  always_comb begin
    logic [7:0]  v;
    logic [15:0] sum_add, nidx, room;
    logic [16:0] addr;
    phase_d = phase_q; zrun_d = zrun_q; cmd_d = cmd_q; len_d = len_q; idx_d = idx_q;
    sum_d = sum_q; rsum_d = rsum_q; st_d = st_q; pf_d = pf_q; img_d = img_q;
    for (int k = 0; k < 4; k++) set_d[k] = set_q[k];
    res_d = '0;
    v = q_item_i.rx_byte;
    sum_add = sum_q + {8'h00, v};
    nidx = idx_q + 16'd1;
    addr = {4'd0, img_q} + {1'b0, idx_q};
    room = 16'(plpr_pkg::ImageBytes) - {3'd0, img_q};
    if (q_item_i.finished) begin
      pf_d = 1'b1;
    end else begin
      if (q_item_i.hard_to) begin
        phase_d = plpr_pkg::PH_SYNC1; zrun_d = '0; cmd_d = '0; len_d = '0; idx_d = '0;
        sum_d = '0; rsum_d = '0; st_d = '0; pf_d = 1'b0; img_d = '0;
        for (int k = 0; k < 4; k++) set_d[k] = '0;
      end
      if (q_item_i.soft_to) phase_d = plpr_pkg::PH_SYNC1;
      // hard timeout clears sums, so recompute from cleared values
      if (q_item_i.hard_to) begin
        sum_add = {8'h00, v};
        nidx = 16'd1;
        addr = 17'd0;
        room = 16'(plpr_pkg::ImageBytes);
      end
      case (phase_d)
        plpr_pkg::PH_SYNC1: begin
          if (q_item_i.is_sync1) begin
            phase_d = plpr_pkg::PH_SYNC2; zrun_d = '0;
          end else if (q_item_i.is_zero) begin
            zrun_d = zrun_d + 5'd1;
            if (zrun_d == 5'd16) begin
              phase_d = plpr_pkg::PH_SYNC1; zrun_d = '0; cmd_d = '0; len_d = '0;
              idx_d = '0; sum_d = '0; rsum_d = '0; st_d = '0; pf_d = 1'b0; img_d = '0;
              for (int k = 0; k < 4; k++) set_d[k] = '0;
            end
          end
        end
        plpr_pkg::PH_SYNC2: begin
          if (q_item_i.is_sync2) begin
            phase_d = plpr_pkg::PH_CMD; sum_d = '0; idx_d = '0;
          end else phase_d = plpr_pkg::PH_SYNC1;
        end
        plpr_pkg::PH_CMD: begin
          cmd_d = v; sum_d = sum_add; phase_d = plpr_pkg::PH_COMP;
        end
        plpr_pkg::PH_COMP: begin
          sum_d = sum_add;
          if (!q_item_i.is_zero) st_d[plpr_pkg::StPktErr] = 1'b1;
          phase_d = plpr_pkg::PH_LENL;
        end
        plpr_pkg::PH_LENL: begin
          sum_d = sum_add; len_d = {8'h00, v}; phase_d = plpr_pkg::PH_LENH;
        end
        plpr_pkg::PH_LENH: begin
          sum_d = sum_add;
          len_d = {v, len_d[7:0]};
          if (cmd_d == plpr_pkg::CmdTransfer) len_d = xfer_len_q;
          phase_d = (len_d != 16'd0) ? plpr_pkg::PH_DATA : plpr_pkg::PH_SUML;
        end
        plpr_pkg::PH_DATA: begin
          sum_d = sum_add;
          if (idx_d < 16'd4) set_d[idx_d[1:0]] = v;
          if (cmd_d == plpr_pkg::CmdData && addr < 17'(plpr_pkg::ImageBytes)) begin
            res_d.write_enable = 1'b1;
            res_d.write_address = addr[AW-1:0];
            res_d.write_data = v;
          end
          idx_d = nidx;
          if (nidx == len_d) phase_d = plpr_pkg::PH_SUML;
        end
        plpr_pkg::PH_SUML: begin
          rsum_d = {8'h00, v}; phase_d = plpr_pkg::PH_SUMH;
        end
        plpr_pkg::PH_SUMH: begin
          rsum_d = {v, rsum_d[7:0]};
          if (rsum_d != sum_d) st_d[plpr_pkg::StCksum] = 1'b1;
          if (cmd_d == plpr_pkg::CmdTransfer) st_d[plpr_pkg::StCksum] = 1'b0;
          res_d.reply_byte = plpr_pkg::DeviceId;
          phase_d = plpr_pkg::PH_ALIVE;
        end
        plpr_pkg::PH_ALIVE: begin
          res_d.reply_byte = {3'd0, st_d};
          phase_d = plpr_pkg::PH_STATUS;
        end
        plpr_pkg::PH_STATUS: begin
          phase_d = plpr_pkg::PH_SYNC1;
          if (cmd_d == plpr_pkg::CmdInit) begin
            zrun_d = '0; cmd_d = '0; len_d = '0; rsum_d = '0; st_d = '0; pf_d = 1'b0;
            img_d = '0;
            for (int k = 0; k < 4; k++) set_d[k] = '0;
          end else if (cmd_d == plpr_pkg::CmdData) begin
            if ({3'd0, img_d} < 16'(plpr_pkg::ImageBytes))
              img_d = img_d + ((len_d <= room) ? len_d[AW-1:0] : room[AW-1:0]);
            st_d[plpr_pkg::StReady] = 1'b1;
            res_d.data_event = 1'b1;
          end else if (cmd_d == plpr_pkg::CmdPrint || cmd_d == plpr_pkg::CmdTransfer) begin
            st_d[plpr_pkg::StReady] = 1'b0;
            st_d[plpr_pkg::StPrinting] = 1'b1;
            st_d[plpr_pkg::StFull] = 1'b1;
            res_d.print_event = 1'b1;
            res_d.sheets = set_d[0]; res_d.margins = set_d[1];
            res_d.palette = set_d[2]; res_d.exposure = set_d[3];
          end else if (cmd_d == plpr_pkg::CmdStatus) begin
            st_d[plpr_pkg::StReady] = 1'b0;
            if (st_d[plpr_pkg::StPrinting] && pf_d) begin
              st_d[plpr_pkg::StPrinting] = 1'b0; pf_d = 1'b0;
              res_d.complete_event = 1'b1;
            end
          end
          idx_d = '0; sum_d = '0;
        end
        default: phase_d = plpr_pkg::PH_SYNC1;
      endcase
    end
    res_d.image_bytes = img_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= plpr_pkg::PH_SYNC1; zrun_q <= '0; cmd_q <= '0; len_q <= '0;
      idx_q <= '0; sum_q <= '0; rsum_q <= '0; st_q <= '0; pf_q <= 1'b0; img_q <= '0;
      for (int k = 0; k < 4; k++) set_q[k] <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; zrun_q <= zrun_d; cmd_q <= cmd_d; len_q <= len_d;
        idx_q <= idx_d; sum_q <= sum_d; rsum_q <= rsum_d; st_q <= st_d; pf_q <= pf_d;
        img_q <= img_d;
        for (int k = 0; k < 4; k++) set_q[k] <= set_d[k];
        ovalid_q <= 1'b1;
      end else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

endmodule

// File: src/printer_link_packet_receiver.sv
// ----------------------------------------------------------------------------
// printer_link_packet_receiver
// printer side of a byte-serial link: deframes packets, replies, writes image
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// input   | in_valid_i / in_ready_o          | byte or finished report in
// output  | out_valid_o / out_ready_i        | one result per transaction
// config  | cfg_we_i, cfg_index_i, cfg_data_i| write only, no wait
// one transaction per cycle sustained while out_ready_i is high; each passes
// the two-entry queue, then the result register. the back state machine takes
// one transaction per cycle while the result register is free or being taken.
// output stalls fill the queue, then drop in_ready_o. reset clears all but queue/result data.
module printer_link_packet_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [19:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic [19:0]                 gap_us_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  reply_byte_o,
  output logic                        write_enable_o,
  output logic [plpr_pkg::AddrW-1:0]  write_address_o,
  output logic [7:0]                  write_data_o,
  output logic                        data_event_o,
  output logic                        print_event_o,
  output logic                        complete_event_o,
  output logic [7:0]                  sheets_o,
  output logic [7:0]                  margins_o,
  output logic [7:0]                  palette_o,
  output logic [7:0]                  exposure_o,
  output logic [plpr_pkg::AddrW-1:0]  image_bytes_o
);

  logic q_valid, q_ready;
  plpr_pkg::item_t q_item;
  plpr_pkg::result_t res;

  plpr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i, .rx_byte_i, .gap_us_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  plpr_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i(cfg_data_i[15:0]),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .res_o(res)
  );

  assign reply_byte_o     = res.reply_byte;
  assign write_enable_o   = res.write_enable;
  assign write_address_o  = res.write_address;
  assign write_data_o     = res.write_data;
  assign data_event_o     = res.data_event;
  assign print_event_o    = res.print_event;
  assign complete_event_o = res.complete_event;
  assign sheets_o         = res.sheets;
  assign margins_o        = res.margins;
  assign palette_o        = res.palette;
  assign exposure_o       = res.exposure;
  assign image_bytes_o    = res.image_bytes;

`include "printer_link_packet_receiver_assert.svh"

  // results are never overwritten while stalled
  `PLPR_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(reply_byte_o), "result lost under stall")
  // at most one event per result
  `PLPR_ASSERT(a_events, !out_valid_o || $onehot0({data_event_o, print_event_o, complete_event_o}), "several events at once")
  // image writes stay inside the buffer
  `PLPR_ASSERT(a_addr, !(out_valid_o && write_enable_o) || write_address_o < plpr_pkg::AddrW'(plpr_pkg::ImageBytes), "write beyond buffer")

endmodule
